// ----- rtl/blist_pkg.sv -----
// ---------------------------------------------------------------------------
// blist_pkg: shared constants and types of the bounded list engine
// Holds the store geometry, command and status codes, and the command and
// status bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package blist_pkg;

   // store geometry
   localparam int CAPACITY  = 256;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int LEN_W     = $clog2(CAPACITY + 1);

   // field widths
   localparam int CMD_W     = 3;
   localparam int IDX_W     = 9;
   localparam int VAL_W     = 64;
   localparam int OUT_LEN_W = 9;
   localparam int STATUS_W  = 2;
   localparam int CMP_W     = (LEN_W > IDX_W) ? LEN_W : IDX_W;
   localparam int MEM_W     = VAL_W + 1;

   // commands
   localparam logic [CMD_W-1:0] CMD_GET         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET         = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWAP_DELETE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESIZE      = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // read address select
   localparam logic [1:0] RD_SEL_IDX      = 2'd0;
   localparam logic [1:0] RD_SEL_PTR_NEXT = 2'd1;
   localparam logic [1:0] RD_SEL_LAST     = 2'd2;

   // write address select
   localparam logic [1:0] WA_SEL_IDX = 2'd0;
   localparam logic [1:0] WA_SEL_LEN = 2'd1;
   localparam logic [1:0] WA_SEL_PTR = 2'd2;

   // write data select
   localparam logic [1:0] WD_SEL_INPUT = 2'd0;
   localparam logic [1:0] WD_SEL_READ  = 2'd1;
   localparam logic [1:0] WD_SEL_NIL   = 2'd2;

   // pointer update
   localparam logic [1:0] PTR_HOLD     = 2'd0;
   localparam logic [1:0] PTR_LOAD_IDX = 2'd1;
   localparam logic [1:0] PTR_LOAD_LEN = 2'd2;
   localparam logic [1:0] PTR_INC      = 2'd3;

   // length update
   localparam logic [1:0] LEN_HOLD      = 2'd0;
   localparam logic [1:0] LEN_INC       = 2'd1;
   localparam logic [1:0] LEN_DEC       = 2'd2;
   localparam logic [1:0] LEN_LOAD_NLEN = 2'd3;

   typedef struct packed {
      logic                load_req;
      logic                mem_rd;
      logic [1:0]          rd_sel;
      logic                mem_wr;
      logic [1:0]          wa_sel;
      logic [1:0]          wd_sel;
      logic [1:0]          ptr_op;
      logic [1:0]          len_op;
      logic                capture_old;
      logic                resp_load;
      logic                resp_use_old;
      logic [STATUS_W-1:0] resp_status;
   } blist_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             range_err;
      logic             full;
      logic             nlen_over;
      logic             shift_done;
      logic             fill_done;
      logic             rsp_busy;
   } blist_sts_type;

endpackage

// ----- rtl/blist_dp.sv -----
// ---------------------------------------------------------------------------
// blist_dp: datapath of the bounded list engine
// Element store with its nil marks, length and walk pointer, captured
// request, and the response register.
// ---------------------------------------------------------------------------
module blist_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  blist_pkg::blist_cmd_type       ctl,
   output blist_pkg::blist_sts_type       sts,
   input  logic [blist_pkg::CMD_W-1:0]    req_cmd,
   input  logic [blist_pkg::IDX_W-1:0]    req_index,
   input  logic [blist_pkg::VAL_W-1:0]    req_value,
   input  logic [blist_pkg::IDX_W-1:0]    req_new_length,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [blist_pkg::VAL_W-1:0]    rsp_value_out,
   output logic                           rsp_value_present,
   output logic [blist_pkg::OUT_LEN_W-1:0] rsp_length,
   output logic [blist_pkg::STATUS_W-1:0] rsp_status
);
   import blist_pkg::*;

   // store word: {nil mark, value}
   logic [MEM_W-1:0]    elem_mem [CAPACITY];

   logic [CMD_W-1:0]    cmd_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [VAL_W-1:0]    val_ff;
   logic [IDX_W-1:0]    nlen_ff;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    ptr_ff, ptr_in;
   logic [MEM_W-1:0]    rd_data_ff;
   logic [VAL_W-1:0]    old_val_ff;
   logic                old_nil_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]    rsp_value_ff;
   logic                rsp_present_ff;
   logic [OUT_LEN_W-1:0] rsp_length_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [CMP_W-1:0]    idx_ext, len_ext, nlen_ext;
   logic [LEN_W-1:0]    ptr_next, len_last;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [MEM_W-1:0]    wr_data;
   logic                present;

   assign idx_ext  = CMP_W'(idx_ff);
   assign len_ext  = CMP_W'(len_ff);
   assign nlen_ext = CMP_W'(nlen_ff);
   assign ptr_next = ptr_ff + LEN_W'(1);
   assign len_last = len_ff - LEN_W'(1);

   assign sts.cmd        = cmd_ff;
   assign sts.range_err  = idx_ext >= len_ext;
   assign sts.full       = len_ff >= LEN_W'(CAPACITY);
   assign sts.nlen_over  = nlen_ext > CMP_W'(CAPACITY);
   assign sts.shift_done = ptr_next >= len_ff;
   assign sts.fill_done  = ptr_ff >= nlen_ext[LEN_W-1:0];
   assign sts.rsp_busy   = rsp_valid_ff & rsp_stall;

   always_comb begin
      case (ctl.rd_sel)
         RD_SEL_PTR_NEXT: rd_addr = ptr_next[ADDR_W-1:0];
         RD_SEL_LAST:     rd_addr = len_last[ADDR_W-1:0];
         default:         rd_addr = idx_ext[ADDR_W-1:0];
      endcase
      case (ctl.wa_sel)
         WA_SEL_LEN: wr_addr = len_ff[ADDR_W-1:0];
         WA_SEL_PTR: wr_addr = ptr_ff[ADDR_W-1:0];
         default:    wr_addr = idx_ext[ADDR_W-1:0];
      endcase
      case (ctl.wd_sel)
         WD_SEL_READ: wr_data = rd_data_ff;
         WD_SEL_NIL:  wr_data = {1'b1, {VAL_W{1'b0}}};
         default:     wr_data = {1'b0, val_ff};
      endcase
   end

   always_comb begin
      case (ctl.ptr_op)
         PTR_LOAD_IDX: ptr_in = idx_ext[LEN_W-1:0];
         PTR_LOAD_LEN: ptr_in = len_ff;
         PTR_INC:      ptr_in = ptr_next;
         default:      ptr_in = ptr_ff;
      endcase
      case (ctl.len_op)
         LEN_INC:       len_in = len_ff + LEN_W'(1);
         LEN_DEC:       len_in = len_last;
         LEN_LOAD_NLEN: len_in = nlen_ext[LEN_W-1:0];
         default:       len_in = len_ff;
      endcase
   end

   assign present = ctl.resp_use_old & ~old_nil_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         elem_mem[wr_addr] <= wr_data;
      end
      if (ctl.mem_rd) begin
         rd_data_ff <= elem_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff  <= req_cmd;
         idx_ff  <= req_index;
         val_ff  <= req_value;
         nlen_ff <= req_new_length;
      end
      if (ctl.capture_old) begin
         old_val_ff <= rd_data_ff[VAL_W-1:0];
         old_nil_ff <= rd_data_ff[VAL_W];
      end
      ptr_ff <= ptr_in;
      if (ctl.resp_load) begin
         rsp_value_ff   <= present ? old_val_ff : '0;
         rsp_present_ff <= present;
         rsp_length_ff  <= len_ext[OUT_LEN_W-1:0];
         rsp_status_ff  <= ctl.resp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_value_present = rsp_present_ff;
   assign rsp_length        = rsp_length_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- rtl/blist_ctrl.sv -----
// ---------------------------------------------------------------------------
// blist_ctrl: sequencer of the bounded list engine
// Decodes the captured command and steps the datapath through reads,
// shift and fill walks, and the response load.
// ---------------------------------------------------------------------------
module blist_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  blist_pkg::blist_sts_type sts,
   output blist_pkg::blist_cmd_type ctl
);
   import blist_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_RD_OLD = 4'd2;
   localparam logic [3:0] S_SH_CHK = 4'd3;
   localparam logic [3:0] S_SH_WR  = 4'd4;
   localparam logic [3:0] S_SW_WR  = 4'd5;
   localparam logic [3:0] S_FILL   = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   logic [3:0]          state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                use_old_ff, use_old_in;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      use_old_in = use_old_ff;
      ctl        = '0;
      ctl.resp_status  = status_ff;
      ctl.resp_use_old = use_old_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in  = ST_OK;
            use_old_in = 1'b0;
            state_in   = S_RESP;
            case (sts.cmd)
               CMD_GET, CMD_SET, CMD_DELETE, CMD_SWAP_DELETE: begin
                  if (sts.range_err) begin
                     status_in = ST_RANGE;
                  end else begin
                     ctl.mem_rd = 1'b1;
                     ctl.rd_sel = RD_SEL_IDX;
                     state_in   = S_RD_OLD;
                  end
               end
               CMD_PUSH: begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.mem_wr = 1'b1;
                     ctl.wa_sel = WA_SEL_LEN;
                     ctl.wd_sel = WD_SEL_INPUT;
                     ctl.len_op = LEN_INC;
                  end
               end
               CMD_RESIZE: begin
                  if (sts.nlen_over) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.ptr_op = PTR_LOAD_LEN;
                     state_in   = S_FILL;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_RD_OLD: begin
            ctl.capture_old = 1'b1;
            use_old_in      = 1'b1;
            state_in        = S_RESP;
            case (sts.cmd)
               CMD_SET: begin
                  ctl.mem_wr = 1'b1;
                  ctl.wa_sel = WA_SEL_IDX;
                  ctl.wd_sel = WD_SEL_INPUT;
               end
               CMD_DELETE: begin
                  ctl.ptr_op = PTR_LOAD_IDX;
                  state_in   = S_SH_CHK;
               end
               CMD_SWAP_DELETE: begin
                  ctl.mem_rd = 1'b1;
                  ctl.rd_sel = RD_SEL_LAST;
                  state_in   = S_SW_WR;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SH_CHK: begin
            if (sts.shift_done) begin
               ctl.len_op = LEN_DEC;
               state_in   = S_RESP;
            end else begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_SEL_PTR_NEXT;
               state_in   = S_SH_WR;
            end
         end
         S_SH_WR: begin
            ctl.mem_wr = 1'b1;
            ctl.wa_sel = WA_SEL_PTR;
            ctl.wd_sel = WD_SEL_READ;
            ctl.ptr_op = PTR_INC;
            state_in   = S_SH_CHK;
         end
         S_SW_WR: begin
            ctl.mem_wr = 1'b1;
            ctl.wa_sel = WA_SEL_IDX;
            ctl.wd_sel = WD_SEL_READ;
            ctl.len_op = LEN_DEC;
            state_in   = S_RESP;
         end
         S_FILL: begin
            if (sts.fill_done) begin
               ctl.len_op = LEN_LOAD_NLEN;
               state_in   = S_RESP;
            end else begin
               ctl.mem_wr = 1'b1;
               ctl.wa_sel = WA_SEL_PTR;
               ctl.wd_sel = WD_SEL_NIL;
               ctl.ptr_op = PTR_INC;
            end
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               ctl.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      use_old_ff <= use_old_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- rtl/bounded_list_engine.sv -----
// Sequence: get and set decode, then read the old entry; push, refused and out-of-range
//   commands load the result after decode; swap delete also moves the last entry; ordered
//   delete shifts each later entry down in turn; resize writes each nil entry added.
// Throughput: one command at a time; the single store port paces the shift and
//   fill walks, and req_stall holds the next request off until the result is loaded.
// Reset: synchronous, active high; list empty, no result pending. No store sweep.
// ---------------------------------------------------------------------------
// bounded_list_engine: fixed-capacity ordered list of 64-bit values
// Get, set, push, ordered delete, swap delete and resize over a store of
// CAPACITY entries; every command answers one result transfer.
// ---------------------------------------------------------------------------
module bounded_list_engine (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [blist_pkg::CMD_W-1:0]     req_cmd,
   input  logic [blist_pkg::IDX_W-1:0]     req_index,
   input  logic [blist_pkg::VAL_W-1:0]     req_value,
   input  logic [blist_pkg::IDX_W-1:0]     req_new_length,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [blist_pkg::VAL_W-1:0]     rsp_value_out,
   output logic                            rsp_value_present,
   output logic [blist_pkg::OUT_LEN_W-1:0] rsp_length,
   output logic [blist_pkg::STATUS_W-1:0]  rsp_status
);
   import blist_pkg::*;

   // Controller and datapath talk only through these two bundles.
   // The datapath keeps each store word as {nil mark, value}; every entry
   // below the length was written by push, set, a shift or a resize fill,
   // so the store needs no clearing after reset.
   blist_cmd_type ctl;
   blist_sts_type sts;

   // Sequencer: capture the request, decode it, walk the store one entry
   // per step for ordered deletes and resizes, then load the result register.
   // A finished result parks in the datapath's output register, so the
   // next request transfer can land while that result is still stalled.
   blist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Datapath: element store, length and pointer registers, range checks
   // and the result register that drives the rsp_ channel.
   blist_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_value         (req_value),
      .req_new_length    (req_new_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_out     (rsp_value_out),
      .rsp_value_present (rsp_value_present),
      .rsp_length        (rsp_length),
      .rsp_status        (rsp_status)
   );

endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: self-checking bench for bounded_list_engine
// Drives get, set, push, ordered delete, swap delete, resize and the two
// spare command codes through the request channel. A local copy of the list
// predicts every answer. A monitor compares each result transfer field by
// field against the oldest prediction. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import blist_pkg::*;

   // spare command codes: the block must answer them with nil and status ok
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   localparam int TOTAL_ITEMS   = 1350;
   localparam int FILL_AT       = 320;   // commands queued before the fill burst
   localparam int DRAIN_AT      = 750;   // command that waits for an empty pipeline
   localparam int SHRINK_AT     = 1000;  // commands queued before a shrink to a few
   localparam int HOLD_AT       = 500;   // results seen before the long hold-off
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
   localparam int PRINT_LIMIT   = 40;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] new_length;
      bit               wait_drain;
   } list_request_type;

   typedef struct {
      logic [VAL_W-1:0]     value_out;
      logic                 present;
      logic [OUT_LEN_W-1:0] length;
      logic [STATUS_W-1:0]  status;
   } list_answer_type;

   // ------------------------------------------------------------------------
   // clock, reset and block ports
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd        = '0;
   logic [IDX_W-1:0]     req_index      = '0;
   logic [VAL_W-1:0]     req_value      = '0;
   logic [IDX_W-1:0]     req_new_length = '0;

   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [VAL_W-1:0]     rsp_value_out;
   logic                 rsp_value_present;
   logic [OUT_LEN_W-1:0] rsp_length;
   logic [STATUS_W-1:0]  rsp_status;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bounded_list_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_value         (req_value),
      .req_new_length    (req_new_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_out     (rsp_value_out),
      .rsp_value_present (rsp_value_present),
      .rsp_length        (rsp_length),
      .rsp_status        (rsp_status)
   );

   // ------------------------------------------------------------------------
   // shared bench state
   // ------------------------------------------------------------------------
   list_request_type pending_commands[$];   // filled at time zero, drained by driver
   list_answer_type  expected_answers[$];   // one per accepted command, oldest first

   // local copy of the list, advanced at each request transfer
   logic [VAL_W-1:0] shadow_words[CAPACITY];
   bit               shadow_nil[CAPACITY];
   int unsigned      shadow_len = 0;

   int unsigned plan_len      = 0;   // list length as the stimulus builder sees it
   int          total_queued  = 0;
   int          accepted_count = 0;
   int          answers_seen  = 0;
   int          mismatch_count = 0;

   // coverage tallies for the closing summary
   int          cmd_tally[8];
   int          range_count = 0;
   int          full_count  = 0;
   int          nil_count   = 0;
   int unsigned peak_len    = 0;

   initial begin
      foreach (shadow_nil[i]) shadow_nil[i] = 1'b1;
      foreach (cmd_tally[i]) cmd_tally[i] = 0;
   end

   // ------------------------------------------------------------------------
   // list predictor: apply one command to the local copy, return its answer
   // ------------------------------------------------------------------------
   function automatic list_answer_type apply_list_command(input list_request_type rq);
      list_answer_type ans;
      int unsigned     i;
      ans.value_out = '0;
      ans.present   = 1'b0;
      ans.status    = ST_OK;
      case (rq.cmd)
         CMD_GET, CMD_SET, CMD_DELETE, CMD_SWAP_DELETE: begin
            if (rq.index >= shadow_len) begin
               // out of range: nothing moves, answer nil
               ans.status = ST_RANGE;
            end else begin
               ans.present = !shadow_nil[rq.index];
               if (ans.present) ans.value_out = shadow_words[rq.index];
               if (rq.cmd == CMD_SET) begin
                  shadow_words[rq.index] = rq.value;
                  shadow_nil[rq.index]   = 1'b0;
               end else if (rq.cmd == CMD_DELETE) begin
                  // close the gap: every later entry moves down one place
                  for (i = 32'(rq.index); i + 1 < shadow_len; i++) begin
                     shadow_words[i] = shadow_words[i + 1];
                     shadow_nil[i]   = shadow_nil[i + 1];
                  end
                  shadow_len--;
               end else if (rq.cmd == CMD_SWAP_DELETE) begin
                  // the last entry takes the freed slot
                  shadow_words[rq.index] = shadow_words[shadow_len - 1];
                  shadow_nil[rq.index]   = shadow_nil[shadow_len - 1];
                  shadow_len--;
               end
            end
         end
         CMD_PUSH: begin
            if (shadow_len >= CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = rq.value;
               shadow_nil[shadow_len]   = 1'b0;
               shadow_len++;
            end
         end
         CMD_RESIZE: begin
            if (rq.new_length > CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               // grow with nil entries, or simply truncate
               for (i = shadow_len; i < rq.new_length; i++) shadow_nil[i] = 1'b1;
               shadow_len = 32'(rq.new_length);
            end
         end
         default: ;   // spare codes change nothing
      endcase
      ans.length = shadow_len[OUT_LEN_W-1:0];
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_command(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] v, input logic [IDX_W-1:0] nl,
                                input bit drain);
      list_request_type rq;
      rq.cmd        = c;
      rq.index      = idx;
      rq.value      = v;
      rq.new_length = nl;
      rq.wait_drain = drain;
      pending_commands.push_back(rq);
      total_queued++;
      // track the length so random indexes mostly land inside the list
      case (c)
         CMD_PUSH:                    if (plan_len < CAPACITY) plan_len++;
         CMD_DELETE, CMD_SWAP_DELETE: if (idx < plan_len) plan_len--;
         CMD_RESIZE:                  if (nl <= CAPACITY) plan_len = 32'(nl);
         default: ;
      endcase
   endtask

   function automatic logic [VAL_W-1:0] random_word();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '1;
      if (r == 1) return '0;
      if (r == 2) return 64'd1 << $urandom_range(0, 63);
      return {$urandom, $urandom};
   endfunction

   // mostly a live position, sometimes anywhere in the index field
   function automatic logic [IDX_W-1:0] random_index();
      if (plan_len > 0 && $urandom_range(0, 99) < 85)
         return IDX_W'($urandom_range(0, plan_len - 1));
      return IDX_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [IDX_W-1:0] random_new_length();
      int unsigned r;
      int unsigned top;
      r   = $urandom_range(0, 99);
      top = (plan_len + 16 > CAPACITY) ? CAPACITY : plan_len + 16;
      if (r < 75) return IDX_W'($urandom_range(0, top));
      if (r < 80) return IDX_W'(CAPACITY);
      return IDX_W'($urandom_range(CAPACITY + 1, 511));
   endfunction

   // gap length for either side: calm stretches, mostly short gaps, a few long
   function automatic int pick_gap(inout int calm_left);
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 68) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: result %0d %s: got %h, predicted %h",
                  $time, answers_seen, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // driver: offer queued commands, predict each one at its transfer
   // ------------------------------------------------------------------------
   list_request_type on_offer;
   int               send_gap  = 0;
   int               send_calm = 0;

   always @(posedge clock) begin
      list_answer_type ans;
      logic            next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            // transfer taken: predict now, then idle for a random gap
            ans = apply_list_command(on_offer);
            expected_answers.push_back(ans);
            accepted_count++;
            cmd_tally[on_offer.cmd]++;
            if (ans.status == ST_RANGE) range_count++;
            if (ans.status == ST_FULL) full_count++;
            if (ans.status == ST_OK && !ans.present &&
                (on_offer.cmd == CMD_GET || on_offer.cmd == CMD_SET ||
                 on_offer.cmd == CMD_DELETE || on_offer.cmd == CMD_SWAP_DELETE))
               nil_count++;
            if (shadow_len > peak_len) peak_len = shadow_len;
            next_valid = 1'b0;
            send_gap   = pick_gap(send_calm);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_commands.size() > 0 &&
                         (!pending_commands[0].wait_drain || expected_answers.size() == 0)) begin
               // hold a draining command back until every answer is home
               on_offer       = pending_commands.pop_front();
               req_cmd        <= on_offer.cmd;
               req_index      <= on_offer.index;
               req_value      <= on_offer.value;
               req_new_length <= on_offer.new_length;
               next_valid     = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: stall at random, check every result transfer
   // ------------------------------------------------------------------------
   int rcv_gap   = 0;
   int rcv_calm  = 0;
   int long_hold = 0;

   always @(posedge clock) begin
      list_answer_type want;
      logic            next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               report_mismatch("arrived with nothing pending", rsp_value_out, '0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_value_out !== want.value_out)
                  report_mismatch("value_out", rsp_value_out, want.value_out);
               if (rsp_value_present !== want.present)
                  report_mismatch("value_present", VAL_W'(rsp_value_present),
                                  VAL_W'(want.present));
               if (rsp_length !== want.length)
                  report_mismatch("length", VAL_W'(rsp_length), VAL_W'(want.length));
               if (rsp_status !== want.status)
                  report_mismatch("status", VAL_W'(rsp_status), VAL_W'(want.status));
            end
            // back up the block once: hold results while the sender keeps offering
            if (answers_seen == HOLD_AT) long_hold = HOLD_CYCLES;
         end
         if (long_hold > 0) begin
            long_hold--;
            next_stall = 1'b1;
         end else if (rcv_gap > 0) begin
            rcv_gap--;
            next_stall = 1'b1;
         end else begin
            rcv_gap    = pick_gap(rcv_calm);
            next_stall = (rcv_gap > 0);
            if (next_stall) rcv_gap--;
         end
         rsp_stall <= next_stall;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      int               pick;
      logic [CMD_W-1:0] c;
      bit               filled;
      bit               drained;
      bit               shrunk;
      filled  = 1'b0;
      drained = 1'b0;
      shrunk  = 1'b0;

      // directed: empty-list range errors, then values, nil fill and limits
      queue_command(CMD_GET,         9'd0,   random_word(), 9'd0,   1'b0);
      queue_command(CMD_SET,         9'd0,   random_word(), 9'd0,   1'b0);
      queue_command(CMD_DELETE,      9'd0,   random_word(), 9'd0,   1'b0);
      queue_command(CMD_SWAP_DELETE, 9'd0,   random_word(), 9'd0,   1'b0);
      queue_command(CMD_RESIZE,      9'd0,   '0,            9'd0,   1'b0);
      queue_command(CMD_PUSH,        9'd0,   '1,            9'd0,   1'b0);
      queue_command(CMD_PUSH,        9'd511, '0,            9'd511, 1'b0);
      queue_command(CMD_PUSH,        9'd0,   64'h0123_4567_89ab_cdef, 9'd0, 1'b0);
      queue_command(CMD_GET,         9'd0,   '0,            9'd0,   1'b0);
      queue_command(CMD_GET,         9'd3,   '0,            9'd0,   1'b0);
      queue_command(CMD_SET,         9'd1,   64'ha5a5_5a5a_f00f_0ff0, 9'd0, 1'b0);
      // grow with nil entries, then read, overwrite and delete a nil one
      queue_command(CMD_RESIZE,      9'd0,   '0,            9'd6,   1'b0);
      queue_command(CMD_GET,         9'd5,   '0,            9'd0,   1'b0);
      queue_command(CMD_SET,         9'd4,   64'hdead_beef_cafe_f00d, 9'd0, 1'b0);
      queue_command(CMD_DELETE,      9'd3,   '0,            9'd0,   1'b0);
      queue_command(CMD_SWAP_DELETE, 9'd0,   '0,            9'd0,   1'b0);
      // refuse oversize resizes, then fill to the ceiling and hit it
      queue_command(CMD_RESIZE,      9'd0,   '0,            IDX_W'(CAPACITY + 1), 1'b0);
      queue_command(CMD_RESIZE,      9'd0,   '0,            9'd511, 1'b0);
      queue_command(CMD_RESIZE,      9'd0,   '0,            IDX_W'(CAPACITY), 1'b0);
      queue_command(CMD_PUSH,        9'd0,   '1,            9'd0,   1'b0);
      queue_command(CMD_GET,         IDX_W'(CAPACITY - 1), '0, 9'd0, 1'b0);
      queue_command(CMD_DELETE,      9'd511, '1,            9'd0,   1'b0);
      queue_command(CMD_UNUSED_6,    9'd511, '1,            9'd511, 1'b0);
      queue_command(CMD_UNUSED_7,    9'd0,   '1,            9'd0,   1'b0);
      queue_command(CMD_RESIZE,      9'd0,   '0,            9'd2,   1'b0);

      // random: mostly live indexes, some wild fields on every command
      while (total_queued < TOTAL_ITEMS) begin
         if (!filled && total_queued >= FILL_AT) begin
            // push to capacity with real values, then bump into the ceiling
            filled = 1'b1;
            while (plan_len < CAPACITY)
               queue_command(CMD_PUSH, random_index(), random_word(), random_new_length(), 1'b0);
            repeat (3)
               queue_command(CMD_PUSH, random_index(), random_word(), random_new_length(), 1'b0);
         end
         if (!drained && total_queued >= DRAIN_AT) begin
            drained = 1'b1;
            queue_command(CMD_GET, random_index(), random_word(), random_new_length(), 1'b1);
         end
         if (!shrunk && total_queued >= SHRINK_AT) begin
            shrunk = 1'b1;
            queue_command(CMD_RESIZE, random_index(), random_word(),
                          IDX_W'($urandom_range(0, 4)), 1'b0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 20)      c = CMD_GET;
         else if (pick < 35) c = CMD_SET;
         else if (pick < 58) c = CMD_PUSH;
         else if (pick < 68) c = CMD_DELETE;
         else if (pick < 80) c = CMD_SWAP_DELETE;
         else if (pick < 92) c = CMD_RESIZE;
         else if (pick < 96) c = CMD_UNUSED_6;
         else                c = CMD_UNUSED_7;
         queue_command(c, random_index(), random_word(), random_new_length(), 1'b0);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for every command to go in and every answer to come back
      while (accepted_count < total_queued || expected_answers.size() != 0)
         @(posedge clock);
      // let a late stray result show up
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d commands: get %0d, set %0d, push %0d, delete %0d, swap %0d, "
               , accepted_count, cmd_tally[CMD_GET], cmd_tally[CMD_SET],
               cmd_tally[CMD_PUSH], cmd_tally[CMD_DELETE], cmd_tally[CMD_SWAP_DELETE],
               "resize %0d, spare codes %0d; peak length %0d",
               cmd_tally[CMD_RESIZE], cmd_tally[CMD_UNUSED_6] + cmd_tally[CMD_UNUSED_7],
               peak_len);
      $display("answers checked %0d: %0d out of range, %0d over capacity, %0d nil entries",
               answers_seen, range_count, full_count, nil_count);
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("timeout: %0d of %0d commands taken, %0d answers pending",
               accepted_count, total_queued, expected_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
